// File: hdl/vfsb64_pkg.sv
// Shared types, constants and lookup functions for the version record scrambler.
// Used by the microcode ROM, the datapath and the top level. No dependencies.
`default_nettype none
package vfsb64_pkg;

    localparam int REC_BYTES     = 20;
    localparam int B64_CHARS     = 28;
    localparam int MAX_KEY_BYTES = 16;
    localparam int PC_W          = 5;

    // configuration register indexes
    localparam logic [2:0] CFG_VERSION_LO = 3'd0;
    localparam logic [2:0] CFG_VERSION_HI = 3'd1;
    localparam logic [2:0] CFG_KEY_LO     = 3'd2;
    localparam logic [2:0] CFG_KEY_HI     = 3'd3;
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd4;

    localparam logic [PC_W-1:0] PC_IDLE = '0;

    typedef enum logic [3:0] {
        OP_IDLE,   // wait for an input item
        OP_XF,     // forward XOR pass, one byte per cycle
        OP_XR,     // reversed XOR pass, one byte per cycle
        OP_APP,    // append the random word big-endian
        OP_SKIPZ,  // jump when key length is zero
        OP_BRM,    // jump when mode is raw
        OP_LDB,    // shift one record byte into the group register
        OP_B64,    // emit one Base64 character
        OP_LOOP,   // next group or finish
        OP_RAW     // emit record bytes
    } t_op;

    typedef struct packed {
        t_op             op;
        logic            hexkey;  // key from hex digits of the random word
        logic            load;    // take version byte instead of buffer byte
        logic            n20;     // pass length 20, else 16
        logic [PC_W-1:0] tgt;
    } t_uword;

    typedef struct packed {
        logic pass_end;
        logic klen_zero;
        logic mode_raw;
        logic all_done;
        logic emit_ok;
        logic rec_last;
    } t_stat;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] w;
        w = {4'd0, v};
        return (v < 4'd10) ? (8'h30 + w) : (8'h57 + w);
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'd0, v};
        if (v < 6'd26)      return 8'h41 + w;
        else if (v < 6'd52) return 8'h47 + w;   // 'a' - 26
        else if (v < 6'd62) return w - 8'd4;    // '0' - 52
        else if (v == 6'd62) return 8'h2B;
        else                return 8'h2F;
    endfunction

endpackage
`default_nettype wire

// File: hdl/vfsb64_rom.sv
// Microprogram ROM: one control word per step address.
// Depends on vfsb64_pkg.
`default_nettype none
module vfsb64_rom (
    input  wire logic [vfsb64_pkg::PC_W-1:0] i_pc,
    output vfsb64_pkg::t_uword               o_uw
);
    localparam logic [vfsb64_pkg::PC_W-1:0] L_BRM  = 5'd7;
    localparam logic [vfsb64_pkg::PC_W-1:0] L_GRP  = 5'd8;
    localparam logic [vfsb64_pkg::PC_W-1:0] L_RAW  = 5'd16;

    always_comb begin
        o_uw = '{vfsb64_pkg::OP_IDLE, 1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
        case (i_pc)
            5'd0:  o_uw = '{vfsb64_pkg::OP_IDLE,  1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
            5'd1:  o_uw = '{vfsb64_pkg::OP_XF,    1'b1, 1'b1, 1'b0, vfsb64_pkg::PC_IDLE};
            5'd2:  o_uw = '{vfsb64_pkg::OP_XR,    1'b1, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
            5'd3:  o_uw = '{vfsb64_pkg::OP_APP,   1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
            5'd4:  o_uw = '{vfsb64_pkg::OP_SKIPZ, 1'b0, 1'b0, 1'b1, L_BRM};
            5'd5:  o_uw = '{vfsb64_pkg::OP_XF,    1'b0, 1'b0, 1'b1, vfsb64_pkg::PC_IDLE};
            5'd6:  o_uw = '{vfsb64_pkg::OP_XR,    1'b0, 1'b0, 1'b1, vfsb64_pkg::PC_IDLE};
            5'd7:  o_uw = '{vfsb64_pkg::OP_BRM,   1'b0, 1'b0, 1'b0, L_RAW};
            5'd8:  o_uw = '{vfsb64_pkg::OP_LDB,   1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
            5'd9:  o_uw = '{vfsb64_pkg::OP_LDB,   1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
            5'd10: o_uw = '{vfsb64_pkg::OP_LDB,   1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
            5'd11: o_uw = '{vfsb64_pkg::OP_B64,   1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
            5'd12: o_uw = '{vfsb64_pkg::OP_B64,   1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
            5'd13: o_uw = '{vfsb64_pkg::OP_B64,   1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
            5'd14: o_uw = '{vfsb64_pkg::OP_B64,   1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
            5'd15: o_uw = '{vfsb64_pkg::OP_LOOP,  1'b0, 1'b0, 1'b0, L_GRP};
            5'd16: o_uw = '{vfsb64_pkg::OP_RAW,   1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
            default: o_uw = '{vfsb64_pkg::OP_IDLE, 1'b0, 1'b0, 1'b0, vfsb64_pkg::PC_IDLE};
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/vfsb64_dp.sv
// Datapath: configuration registers, 20-byte work buffer, byte counters,
// Base64 group register and output register. Depends on vfsb64_pkg.
`default_nettype none
module vfsb64_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire vfsb64_pkg::t_uword  i_uw,
    input  wire logic                i_in_acc,
    input  wire logic                i_mode,
    input  wire logic [31:0]         i_rw,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [63:0]         i_cfg_data,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [7:0]               o_out_byte,
    output logic [4:0]               o_out_pos,
    output logic                     o_out_last,
    output vfsb64_pkg::t_stat        o_stat
);
    logic [127:0] r_ver;
    logic [127:0] r_key;
    logic [4:0]   r_klen;
    logic [7:0]   r_buf [vfsb64_pkg::REC_BYTES];
    logic         r_mode;
    logic [31:0]  r_rw;
    logic [4:0]   r_i;
    logic [3:0]   r_k;
    logic [4:0]   r_pos;
    logic [23:0]  r_grp;
    logic         r_ovalid;
    logic [7:0]   r_obyte;
    logic [4:0]   r_opos;
    logic         r_olast;

    logic [4:0] klen_sat;
    logic [4:0] klen_m1;
    logic [3:0] m_last;
    logic [4:0] n_last;
    logic [4:0] addr;
    logic [7:0] rd;
    logic [7:0] ver_b;
    logic [7:0] kb;
    logic [7:0] wdata;
    logic       pass_end;
    logic       emit_ok;
    logic       emit;
    logic [7:0] b64_out;

    always_comb begin
        klen_sat = (r_klen > 5'(vfsb64_pkg::MAX_KEY_BYTES))
                   ? 5'(vfsb64_pkg::MAX_KEY_BYTES) : r_klen;
        klen_m1  = klen_sat - 5'd1;
        m_last   = i_uw.hexkey ? 4'd7 : klen_m1[3:0];
        n_last   = i_uw.n20 ? 5'(vfsb64_pkg::REC_BYTES - 1) : 5'd15;
        addr     = (i_uw.op == vfsb64_pkg::OP_XR) ? (n_last - r_i) : r_i;
        rd       = (addr < 5'(vfsb64_pkg::REC_BYTES)) ? r_buf[addr] : 8'd0;
        ver_b    = r_ver[{addr[3:0], 3'b000} +: 8];
        kb       = i_uw.hexkey ? vfsb64_pkg::hex_char(r_rw[{~r_k[2:0], 2'b00} +: 4])
                               : r_key[{r_k, 3'b000} +: 8];
        wdata    = (i_uw.load ? ver_b : rd) ^ kb;
        pass_end = (r_i == n_last);
        emit_ok  = !r_ovalid || i_out_ready;
        // an emit step loads the output register this cycle
        emit     = emit_ok && (i_uw.op inside {vfsb64_pkg::OP_B64, vfsb64_pkg::OP_RAW});
        // the pad position of the final group shows '='
        b64_out  = (r_pos == 5'(vfsb64_pkg::B64_CHARS - 1))
                   ? 8'h3D : vfsb64_pkg::b64_char(r_grp[23:18]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ver    <= '0;
            r_key    <= '0;
            r_klen   <= '0;
            r_i      <= '0;
            r_k      <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    vfsb64_pkg::CFG_VERSION_LO: r_ver[63:0]    <= i_cfg_data;
                    vfsb64_pkg::CFG_VERSION_HI: r_ver[127:64]  <= i_cfg_data;
                    vfsb64_pkg::CFG_KEY_LO:     r_key[63:0]    <= i_cfg_data;
                    vfsb64_pkg::CFG_KEY_HI:     r_key[127:64]  <= i_cfg_data;
                    vfsb64_pkg::CFG_KEY_LENGTH: r_klen         <= i_cfg_data[4:0];
                    default: ;
                endcase
            end

            if (r_ovalid && i_out_ready && !emit) r_ovalid <= 1'b0;

            case (i_uw.op)
                vfsb64_pkg::OP_IDLE: begin
                    if (i_in_acc) begin
                        r_mode <= i_mode;
                        r_rw   <= i_rw;
                        r_i    <= '0;
                        r_k    <= '0;
                    end
                end
                vfsb64_pkg::OP_XF, vfsb64_pkg::OP_XR: begin
                    r_buf[addr] <= wdata;
                    if (pass_end) begin
                        r_i <= '0;
                        r_k <= '0;
                    end else begin
                        r_i <= r_i + 5'd1;
                        r_k <= (r_k == m_last) ? 4'd0 : r_k + 4'd1;
                    end
                end
                vfsb64_pkg::OP_APP: begin
                    r_buf[16] <= r_rw[31:24];
                    r_buf[17] <= r_rw[23:16];
                    r_buf[18] <= r_rw[15:8];
                    r_buf[19] <= r_rw[7:0];
                end
                vfsb64_pkg::OP_BRM: begin
                    r_i   <= '0;
                    r_pos <= '0;
                end
                vfsb64_pkg::OP_LDB: begin
                    r_grp <= {r_grp[15:0], rd};
                    r_i   <= r_i + 5'd1;
                end
                vfsb64_pkg::OP_B64: begin
                    if (emit_ok) begin
                        r_ovalid <= 1'b1;
                        r_obyte  <= b64_out;
                        r_opos   <= r_pos;
                        r_olast  <= (r_pos == 5'(vfsb64_pkg::B64_CHARS - 1));
                        r_grp    <= {r_grp[17:0], 6'd0};
                        r_pos    <= r_pos + 5'd1;
                    end
                end
                vfsb64_pkg::OP_RAW: begin
                    if (emit_ok) begin
                        r_ovalid <= 1'b1;
                        r_obyte  <= rd;
                        r_opos   <= r_pos;
                        r_olast  <= (r_pos == 5'(vfsb64_pkg::REC_BYTES - 1));
                        r_i      <= r_i + 5'd1;
                        r_pos    <= r_pos + 5'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_out_pos   = r_opos;
    assign o_out_last  = r_olast;

    assign o_stat.pass_end  = pass_end;
    assign o_stat.klen_zero = (r_klen == 5'd0);
    assign o_stat.mode_raw  = !r_mode;
    assign o_stat.all_done  = (r_pos == 5'(vfsb64_pkg::B64_CHARS));
    assign o_stat.emit_ok   = emit_ok;
    assign o_stat.rec_last  = (r_pos == 5'(vfsb64_pkg::REC_BYTES - 1));
endmodule
`default_nettype wire

// File: hdl/version_field_scramble_base64.sv
// Top level of the version record scrambler: step counter, microprogram ROM
// and datapath. Depends on vfsb64_pkg, vfsb64_rom and vfsb64_dp.
//
// Usage:
//   Input stream (i_s_*): one item per record request; tdata carries the
//   32-bit random word, tuser the mode bit (0 raw record, 1 Base64 text).
//   Output stream (o_m_*): one item per emitted byte; tdata carries the byte
//   and its position in the record, tlast marks the final byte (position 19
//   in raw mode, 27 in Base64 mode).
//   Config channel (i_cfg_*): register index and 64-bit data, always ready;
//   write only while no record is in flight.
//   A program of 17 control words drives a byte-serial datapath with a
//   single-port work buffer, so every XOR pass goes through it byte by
//   byte: a 16-byte pass for the hex key, forward and then reversed, and
//   a 20-byte pass each way for the fixed key (skipped when key length
//   is zero), plus sequencing steps. Emission reads the record bytes out
//   raw, or groups of three bytes for Base64 (per group: three loads,
//   four characters, one loop step). Input is taken only in the idle step.
//   Stalls: a stalled receiver holds the sequencer on its emit step; the
//   output register keeps its item until taken.
//   Reset (i_rst_n low, synchronous): return to idle, clear the configuration
//   registers and counters to zero, drop any pending output item.
`default_nettype none
module version_field_scramble_base64 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] random_word
    input  wire logic [0:0]  i_s_tuser,   // [0] mode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [7:0] out_byte, [12:8] position, zero above
    output logic             o_m_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    logic [vfsb64_pkg::PC_W-1:0] r_pc;
    logic [vfsb64_pkg::PC_W-1:0] n_pc;
    vfsb64_pkg::t_uword          uw;
    vfsb64_pkg::t_stat           stat;
    logic                        in_acc;
    logic [7:0]                  out_byte;
    logic [4:0]                  out_pos;

    assign o_s_tready  = (uw.op == vfsb64_pkg::OP_IDLE);
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    vfsb64_rom u_rom (
        .i_pc (r_pc),
        .o_uw (uw)
    );

    vfsb64_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uw        (uw),
        .i_in_acc    (in_acc),
        .i_mode      (i_s_tuser[0]),
        .i_rw        (i_s_tdata),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_byte  (out_byte),
        .o_out_pos   (out_pos),
        .o_out_last  (o_m_tlast),
        .o_stat      (stat)
    );

    assign o_m_tdata = {3'd0, out_pos, out_byte};

    // Step sequencing: advance, hold on a busy step, or jump on a condition.
    always_comb begin
        n_pc = r_pc;
        case (uw.op)
            vfsb64_pkg::OP_IDLE:  if (in_acc) n_pc = r_pc + 1'b1;
            vfsb64_pkg::OP_XF,
            vfsb64_pkg::OP_XR:    if (stat.pass_end) n_pc = r_pc + 1'b1;
            vfsb64_pkg::OP_APP,
            vfsb64_pkg::OP_LDB:   n_pc = r_pc + 1'b1;
            vfsb64_pkg::OP_SKIPZ: n_pc = stat.klen_zero ? uw.tgt : r_pc + 1'b1;
            vfsb64_pkg::OP_BRM:   n_pc = stat.mode_raw ? uw.tgt : r_pc + 1'b1;
            vfsb64_pkg::OP_B64:   if (stat.emit_ok) n_pc = r_pc + 1'b1;
            vfsb64_pkg::OP_LOOP:  n_pc = stat.all_done ? vfsb64_pkg::PC_IDLE : uw.tgt;
            vfsb64_pkg::OP_RAW:   if (stat.emit_ok && stat.rec_last) n_pc = uw.tgt;
            default:              n_pc = vfsb64_pkg::PC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= vfsb64_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end
endmodule
`default_nettype wire

// File: hdl/vfsb64_chk.sv
// Port-level checker for the version record scrambler, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module vfsb64_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata,
    input wire logic        o_m_tlast
);
    // hold a stalled output item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("stalled output item changed");

    // busy after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while record in flight");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> (o_m_tdata[12:8] == 5'd19 || o_m_tdata[12:8] == 5'd27))
        else $error("last item at wrong position");

    a_mid_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[12:8] < 5'd27 && o_m_tdata[15:13] == 3'd0)
        else $error("non-last item at bad position");
endmodule

bind version_field_scramble_base64 vfsb64_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

// File: tb/tb_version_field_scramble_base64.sv
// Self-checking testbench for version_field_scramble_base64: directed table, then random phases.
// Predicts each record from its own copy of the registers; needs vfsb64_pkg and the RTL only.
`default_nettype none
module tb_version_field_scramble_base64;
    timeunit 1ns;
    timeprecision 1ps;

    // indexes with no register behind them; writes there must change nothing
    localparam logic [2:0] CFG_SPARE_A = 3'd5;
    localparam logic [2:0] CFG_SPARE_B = 3'd6;
    localparam logic [2:0] CFG_SPARE_C = 3'd7;

    localparam logic MODE_RAW = 1'b0;
    localparam logic MODE_B64 = 1'b1;

    localparam logic [127:0] HEX_DIGITS = "0123456789abcdef";
    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 75;
    localparam int LONG_HOLD      = 400;   // receiver hold-off, in cycles
    localparam int TAIL_CYCLES    = 200;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    // one row of the directed table; known marks a row whose bytes are typed in
    // (byte p of the record sits at bits 8*(27-p) +: 8 of want)
    typedef struct packed {
        t_row_kind    kind;
        logic [2:0]   idx;
        logic [63:0]  data;
        logic         mode;
        logic [31:0]  rw;
        logic         known;
        logic [223:0] want;
    } t_dir_row;

    typedef struct packed {
        logic [7:0] ch;
        logic [4:0] pos;
        logic       last;
    } t_rec_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // [31:0] random_word
    logic [0:0]  i_s_tuser = '0;   // [0] mode
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // [7:0] out_byte, [12:8] position, [15:13] zero
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    // predictor's copy of the registers, all zero out of reset
    logic [63:0] ver_lo_q = '0;
    logic [63:0] ver_hi_q = '0;
    logic [63:0] key_lo_q = '0;
    logic [63:0] key_hi_q = '0;
    logic [4:0]  key_len_q = '0;

    t_rec_byte pending_bytes[$];
    t_dir_row  dir_tab[$];
    int        mismatch_cnt = 0;
    int        rx_hold_len = 0;
    bit        tx_quiet = 1'b0;

    version_field_scramble_base64 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Hard stop: a run that reaches it reports a mismatch.
    initial begin
        #4_000_000;
        $display("version_field_scramble_base64: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    task automatic expect_byte(input logic [7:0] ch, input int pos, input bit last);
        t_rec_byte e;
        e.ch   = ch;
        e.pos  = pos[4:0];
        e.last = last;
        pending_bytes.push_back(e);
    endtask

    // Build the 20-byte record and queue the bytes the block should emit for it.
    task automatic scramble_record(input logic md, input logic [31:0] rw);
        logic [7:0]  rec [0:19];
        logic [7:0]  hk [0:7];
        logic [7:0]  fk [0:15];
        logic [7:0]  txt [0:27];
        logic [7:0]  b;
        logic [7:0]  c;
        logic [23:0] grp;
        int          nib;
        int          klen;
        for (int i = 0; i < 16; i++)
            rec[i] = (i < 8) ? ver_lo_q[8*i +: 8] : ver_hi_q[8*(i-8) +: 8];
        // hex key: most significant digit first, lower case
        for (int i = 0; i < 8; i++) begin
            nib = int'(rw[4*(7-i) +: 4]);
            hk[i] = HEX_DIGITS[8*(15-nib) +: 8];
        end
        for (int i = 0; i < 16; i++) rec[i] ^= hk[i % 8];
        for (int i = 0; i < 16; i++) rec[15-i] ^= hk[i % 8];
        rec[16] = rw[31:24];
        rec[17] = rw[23:16];
        rec[18] = rw[15:8];
        rec[19] = rw[7:0];
        for (int i = 0; i < 16; i++)
            fk[i] = (i < 8) ? key_lo_q[8*i +: 8] : key_hi_q[8*(i-8) +: 8];
        // saturate oversized key lengths; zero skips the second scramble
        klen = (key_len_q > vfsb64_pkg::MAX_KEY_BYTES)
               ? vfsb64_pkg::MAX_KEY_BYTES : key_len_q;
        if (klen != 0) begin
            for (int i = 0; i < vfsb64_pkg::REC_BYTES; i++)
                rec[i] ^= fk[i % klen];
            for (int i = 0; i < vfsb64_pkg::REC_BYTES; i++)
                rec[vfsb64_pkg::REC_BYTES-1-i] ^= fk[i % klen];
        end

        if (md == MODE_RAW) begin
            for (int i = 0; i < vfsb64_pkg::REC_BYTES; i++)
                expect_byte(rec[i], i, i == vfsb64_pkg::REC_BYTES - 1);
        end else begin
            // seven groups of three, the last padded with a zero byte
            for (int g = 0; g < 7; g++) begin
                b = rec[3*g+1];
                if (3*g + 2 < vfsb64_pkg::REC_BYTES) c = rec[3*g+2];
                else c = 8'h00;
                grp = {rec[3*g], b, c};
                for (int k = 0; k < 4; k++)
                    txt[4*g+k] = B64_ALPHABET[8*(63 - grp[18-6*k +: 6]) +: 8];
            end
            txt[27] = "=";
            for (int i = 0; i < vfsb64_pkg::B64_CHARS; i++)
                expect_byte(txt[i], i, i == vfsb64_pkg::B64_CHARS - 1);
        end
    endtask

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // Write one register and mirror it in the predictor; unknown indexes drop.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            vfsb64_pkg::CFG_VERSION_LO: ver_lo_q = data;
            vfsb64_pkg::CFG_VERSION_HI: ver_hi_q = data;
            vfsb64_pkg::CFG_KEY_LO:     key_lo_q = data;
            vfsb64_pkg::CFG_KEY_HI:     key_hi_q = data;
            vfsb64_pkg::CFG_KEY_LENGTH: key_len_q = data[4:0];
            default: ;
        endcase
    endtask

    // Offer one request, holding it until taken; queue what it should produce.
    task automatic offer_request(input logic md, input logic [31:0] rw,
                                 input logic known, input logic [223:0] want);
        int gap;
        int n;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rw;
        i_s_tuser  <= md;
        do @(posedge i_clk); while (!o_s_tready);
        if (known) begin
            n = (md == MODE_RAW) ? vfsb64_pkg::REC_BYTES : vfsb64_pkg::B64_CHARS;
            for (int p = 0; p < n; p++)
                expect_byte(want[8*(27-p) +: 8], p, p == n - 1);
        end else begin
            scramble_record(md, rw);
        end
    endtask

    // Stop offering and wait until every queued byte has come out.
    task automatic await_records();
        if (i_s_tvalid) i_s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_dir_row cfg_row(input logic [2:0] idx, input logic [63:0] data);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        return r;
    endfunction

    function automatic t_dir_row item_row(input logic md, input logic [31:0] rw);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_ITEM;
        r.mode = md;
        r.rw   = rw;
        return r;
    endfunction

    function automatic t_dir_row known_row(input logic md, input logic [31:0] rw,
                                           input logic [223:0] want);
        t_dir_row r;
        r       = item_row(md, rw);
        r.known = 1'b1;
        r.want  = want;
        return r;
    endfunction

    // all zeros, all ones, or a random word
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Receiver: random stalls per item, quiet stretches, one long hold-off
    // ---------------------------------------------------------------------
    initial begin : receiver
        int  n;
        int  seen;
        bit  rx_quiet;
        seen = 0;
        rx_quiet = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_len > 0) begin
                // starve the output so the block backs up into its input
                i_m_tready <= 1'b0;
                repeat (rx_hold_len) @(posedge i_clk);
                rx_hold_len = 0;
            end
            if (seen % 40 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
            n = rx_quiet ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            seen++;
        end
    end

    // ---------------------------------------------------------------------
    // Checker: every accepted output item against the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : out_check
        t_rec_byte e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected output item, expected none actual %h last %b",
                         $time, o_m_tdata, o_m_tlast);
                mismatch_cnt++;
            end else begin
                e = pending_bytes.pop_front();
                if (o_m_tdata[7:0] !== e.ch) begin
                    $display("%0t: out_byte at position %0d, expected %h actual %h",
                             $time, e.pos, e.ch, o_m_tdata[7:0]);
                    mismatch_cnt++;
                end
                if (o_m_tdata[12:8] !== e.pos) begin
                    $display("%0t: position, expected %0d actual %0d",
                             $time, e.pos, o_m_tdata[12:8]);
                    mismatch_cnt++;
                end
                if (o_m_tlast !== e.last) begin
                    $display("%0t: last at position %0d, expected %b actual %b",
                             $time, e.pos, e.last, o_m_tlast);
                    mismatch_cnt++;
                end
                if (o_m_tdata[15:13] !== 3'b000) begin
                    $display("%0t: tdata padding, expected %b actual %b",
                             $time, 3'b000, o_m_tdata[15:13]);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin : stimulus
        t_dir_row    row;
        logic [63:0] d;
        logic [4:0]  kl;
        logic [2:0]  spare;
        logic [3:0]  nib;
        logic        md;
        logic [31:0] rw;

        // Out of reset every register is zero. A hex key of repeated digits
        // cancels in the two-pass scramble, so these records read off directly.
        dir_tab.push_back(known_row(MODE_RAW, 32'h0, 224'h0));
        dir_tab.push_back(known_row(MODE_B64, 32'h0, "AAAAAAAAAAAAAAAAAAAAAAAAAAA="));
        dir_tab.push_back(known_row(MODE_RAW, 32'hFFFF_FFFF,
                                    {128'h0, 32'hFFFF_FFFF, 64'h0}));
        dir_tab.push_back(known_row(MODE_B64, 32'hFFFF_FFFF, "AAAAAAAAAAAAAAAAAAAAAP////8="));
        dir_tab.push_back(item_row(MODE_RAW, 32'h1234_5678));
        // all-ones version, no fixed key: version bytes pass straight through
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_VERSION_LO, '1));
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_VERSION_HI, '1));
        dir_tab.push_back(known_row(MODE_RAW, 32'h7777_7777,
                                    {{16{8'hFF}}, 32'h7777_7777, 64'h0}));
        dir_tab.push_back(item_row(MODE_B64, 32'hA5C3_0F96));
        // uniform 16-byte key cancels too
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_KEY_LO, '1));
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_KEY_HI, '1));
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_KEY_LENGTH, 64'd16));
        dir_tab.push_back(known_row(MODE_RAW, 32'h0, {{16{8'hFF}}, 32'h0, 64'h0}));
        // mixed key at the shortest and longest lengths
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_KEY_LO, 64'h0123_4567_89AB_CDEF));
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_KEY_HI, 64'hFEDC_BA98_7654_3210));
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_KEY_LENGTH, 64'd1));
        dir_tab.push_back(item_row(MODE_RAW, 32'h0F1E_2D3C));
        dir_tab.push_back(item_row(MODE_B64, 32'hC3B2_A190));
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_KEY_LENGTH, 64'd16));
        dir_tab.push_back(item_row(MODE_RAW, 32'h8000_0000));
        dir_tab.push_back(item_row(MODE_B64, 32'h0000_0001));
        // lengths above the key size saturate; upper data bits are dropped
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_KEY_LENGTH, 64'd17));
        dir_tab.push_back(item_row(MODE_RAW, 32'h5A5A_A5A5));
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_KEY_LENGTH, '1));
        dir_tab.push_back(item_row(MODE_B64, 32'hFFFF_0000));
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_KEY_LENGTH, 64'd7));
        dir_tab.push_back(item_row(MODE_B64, 32'hDEAD_BEEF));
        // writes to unused indexes must leave the record unchanged
        dir_tab.push_back(cfg_row(CFG_SPARE_A, '1));
        dir_tab.push_back(cfg_row(CFG_SPARE_B, '1));
        dir_tab.push_back(cfg_row(CFG_SPARE_C, 64'h0));
        dir_tab.push_back(item_row(MODE_RAW, 32'hDEAD_BEEF));
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_VERSION_LO, 64'h0030_2E31_2E32_2E33));
        dir_tab.push_back(cfg_row(vfsb64_pkg::CFG_VERSION_HI, 64'h0));
        dir_tab.push_back(item_row(MODE_B64, 32'h0BAD_F00D));
        dir_tab.push_back(item_row(MODE_RAW, 32'hFEED_FACE));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            row = dir_tab[r];
            if (row.kind == ROW_CFG) begin
                await_records();
                write_reg(row.idx, row.data);
            end else begin
                offer_request(row.mode, row.rw, row.known, row.want);
            end
        end

        // Random phases: fresh settings each time, extremes of key length first.
        for (int ph = 0; ph < PHASES; ph++) begin
            await_records();
            write_reg(vfsb64_pkg::CFG_VERSION_LO, pick_word());
            write_reg(vfsb64_pkg::CFG_VERSION_HI, pick_word());
            write_reg(vfsb64_pkg::CFG_KEY_LO, pick_word());
            write_reg(vfsb64_pkg::CFG_KEY_HI, pick_word());
            case (ph)
                0:       kl = 5'd0;
                1:       kl = 5'd16;
                2:       kl = 5'd1;
                3:       kl = 5'd31;
                4:       kl = 5'd17;
                default: kl = 5'($urandom_range(0, 31));
            endcase
            d = {$urandom, $urandom};
            d[4:0] = kl;
            write_reg(vfsb64_pkg::CFG_KEY_LENGTH, d);
            case (ph % 3)
                0:       spare = CFG_SPARE_A;
                1:       spare = CFG_SPARE_B;
                default: spare = CFG_SPARE_C;
            endcase
            write_reg(spare, {$urandom, $urandom});

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
                // back-pressure: receiver stops while requests keep coming
                if (ph == 1 && n == 10) rx_hold_len = LONG_HOLD;
                // pause the sender until the block has fully drained
                if (ph == 3 && n == 40) await_records();
                md  = 1'($urandom_range(0, 1));
                nib = 4'($urandom_range(0, 15));
                case ($urandom_range(0, 9))
                    0:       rw = '0;
                    1:       rw = '1;
                    2:       rw = {8{nib}};
                    default: rw = $urandom;
                endcase
                offer_request(md, rw, 1'b0, '0);
            end
        end

        // drain, then watch a while longer for stray output items
        await_records();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_bytes.size() == 0)
            $display("version_field_scramble_base64: match");
        else
            $display("version_field_scramble_base64: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
